// ===== rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic task scheduler package
// Shared types, codes and constants of the periodic task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package pts_pkg;
	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = 4;
	localparam int TIME_BITS = 48;
	localparam int PRIO_W    = 8;
	localparam int PER_W     = 31;

	typedef enum logic [3:0] {
		K_REGISTER   = 4'd0,
		K_UNREGISTER = 4'd1,
		K_SET_ENABLE = 4'd2,
		K_TICK       = 4'd3,
		K_COMPLETION = 4'd4,
		K_READ_STATS = 4'd5,
		K_RESET_STATS= 4'd6,
		K_START      = 4'd7,
		K_STOP       = 4'd8
	} kind_t;

	localparam logic [1:0] R_DUE   = 2'd0;
	localparam logic [1:0] R_COMPL = 2'd1;
	localparam logic [1:0] R_STATS = 2'd2;

	localparam logic [0:0] CFG_WARN_PCT  = 1'b0;
	localparam logic [0:0] CFG_ERR_LIMIT = 1'b1;

	typedef struct packed {
		logic [3:0]           kind;
		logic [SLOT_W-1:0]    slot;
		logic [PRIO_W-1:0]    priority_req;
		logic [PER_W-1:0]     period;
		logic                 mode;
		logic                 enable;
		logic [PER_W-1:0]     warn_threshold;
		logic [TIME_BITS-1:0] now;
		logic [31:0]          cost;
		logic                 success;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [SLOT_W-1:0] task_slot;
		logic              last;
		logic              cost_warning;
		logic              auto_disabled;
		logic              resynced;
		logic [7:0]        error_streak;
		logic [31:0]       run_count;
		logic [31:0]       fail_count;
		logic [31:0]       min_cost;
		logic [31:0]       max_cost;
		logic [47:0]       total_cost;
	} out_item_t;

	// Timing and statistics of one slot, held in the slot memory.
	typedef struct packed {
		logic [TIME_BITS-1:0] last_run;
		logic [TIME_BITS-1:0] next_due;
		logic [7:0]           streak;
		logic [31:0]          runs;
		logic [31:0]          fails;
		logic [31:0]          cmin;
		logic [31:0]          cmax;
		logic [47:0]          csum;
	} slot_rec_t;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	function automatic logic [TIME_BITS-1:0] time_add(input logic [TIME_BITS-1:0] a,
		input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/pts_if.sv =====
// ----------------------------------------------------------------------------
// Periodic task scheduler stream interfaces
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface pts_in_if;
	logic              valid;
	logic              ready;
	pts_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pts_out_if;
	logic               valid;
	logic               ready;
	pts_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pts_mem.sv =====
// ----------------------------------------------------------------------------
// Periodic task scheduler slot memory
// One write port and one registered read port over the slot records.
// ----------------------------------------------------------------------------
`default_nettype none
module pts_mem (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [pts_pkg::SLOT_W-1:0]  waddr,
	input  wire pts_pkg::slot_rec_t          wdata,
	input  wire logic [pts_pkg::SLOT_W-1:0]  raddr,
	output pts_pkg::slot_rec_t               rdata
);
	pts_pkg::slot_rec_t mem [pts_pkg::NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/periodic_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// Periodic task scheduler
// Table of periodic task slots with fixed-delay and fixed-rate scheduling.
// ----------------------------------------------------------------------------
// Sequencing: register, unregister, enable and stop pass through a read and an execute state;
// start clears the times of every slot (no pass when already running). Read stats and
// completion results go to a pending register, then to the output register. A tick makes one
// memory read per slot to decide due bits, then gives one result per cycle unless stalled.
// Throughput: one command at a time; the slot memory read port sets the pace.
// Reset: asynchronous; stopped, all slots invalid, then a clearing pass over every slot record.
`default_nettype none
module periodic_task_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	pts_in_if.sink           cmd,
	pts_out_if.source        res,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [9:0]  cfg_wdata
);
	localparam int SW = pts_pkg::SLOT_W;
	localparam int TB = pts_pkg::TIME_BITS;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RD, ST_EXEC, ST_WARN, ST_TSCAN, ST_TEVAL,
		ST_TSEL, ST_OUT
	} state_t;

	state_t state_q;
	pts_pkg::in_item_t item_q;
	logic [9:0] warn_pct_q;
	logic [7:0] err_lim_q;
	logic running_q;

	// Per-slot configuration is small and lives in flops (read by the selector).
	logic [pts_pkg::NUM_SLOTS-1:0] valid_q, enabled_q, mode_q, due_q;
	logic [pts_pkg::PRIO_W-1:0] prio_q [pts_pkg::NUM_SLOTS];
	logic [pts_pkg::PER_W-1:0]  per_q  [pts_pkg::NUM_SLOTS];
	logic [pts_pkg::PER_W-1:0]  warn_q [pts_pkg::NUM_SLOTS];

	logic [SW:0] cnt_q;
	logic [SW-1:0] scan_q;

	logic mem_we;
	logic [SW-1:0] mem_waddr, mem_raddr;
	pts_pkg::slot_rec_t mem_wdata, rec;

	// The completion and stats results are built in pend_q and then moved to
	// the output register, so a result still waiting there is never disturbed.
	pts_pkg::out_item_t pend_q;
	pts_pkg::out_item_t out_q;
	logic out_valid_q;
	logic out_load;
	logic [40:0] prod_q;
	logic [40:0] cost_x100;

	pts_mem u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(rec)
	);

	function automatic pts_pkg::slot_rec_t cleared_rec();
		pts_pkg::slot_rec_t r;
		r = '0;
		r.cmin = '1;
		return r;
	endfunction

	// Completion arithmetic, from the record read out of memory.
	pts_pkg::slot_rec_t comp_rec;
	logic comp_dis, comp_resync;
	logic [TB-1:0] nd_add;
	logic [48:0] sum_ext;
	always_comb begin
		comp_rec = rec;
		comp_dis = 1'b0;
		comp_resync = 1'b0;
		comp_rec.last_run = pts_pkg::time_add(item_q.now, {16'd0, item_q.cost});
		nd_add = pts_pkg::time_add(rec.next_due, {17'd0, per_q[item_q.slot]});
		if (mode_q[item_q.slot]) begin
			comp_rec.next_due = nd_add;
			if (nd_add < item_q.now) begin
				comp_rec.next_due = pts_pkg::time_add(item_q.now,
					{17'd0, per_q[item_q.slot]});
				comp_resync = 1'b1;
			end
		end
		if (rec.runs != '1) comp_rec.runs = rec.runs + 32'd1;
		sum_ext = {1'b0, rec.csum} + {17'd0, item_q.cost};
		comp_rec.csum = sum_ext[48] ? '1 : sum_ext[47:0];
		if (item_q.cost > rec.cmax) comp_rec.cmax = item_q.cost;
		if (item_q.cost < rec.cmin) comp_rec.cmin = item_q.cost;
		if (item_q.success) begin
			comp_rec.streak = '0;
		end else begin
			if (rec.fails != '1) comp_rec.fails = rec.fails + 32'd1;
			if (rec.streak != 8'hFF) comp_rec.streak = rec.streak + 8'd1;
			comp_dis = (comp_rec.streak >= err_lim_q);
		end
	end

	// The cost exceeds floor(period * percent / 100) exactly when 100 * cost
	// exceeds period * percent, so no divider is needed.
	assign cost_x100 = {3'd0, item_q.cost, 6'd0} + {4'd0, item_q.cost, 5'd0} +
		{7'd0, item_q.cost, 2'd0};

	// Fixed-delay and fixed-rate due decision on a tick, per scanned record.
	logic [TB-1:0] tick_nd;
	logic tick_due;
	logic tick_wb;
	always_comb begin
		tick_nd = rec.next_due;
		tick_wb = 1'b0;
		if (!mode_q[scan_q]) begin
			tick_due = (item_q.now >= rec.last_run) &&
				((item_q.now - rec.last_run) >= {17'd0, per_q[scan_q]});
		end else begin
			if (rec.next_due == '0) begin
				tick_nd = pts_pkg::time_add(item_q.now, {17'd0, per_q[scan_q]});
				tick_wb = 1'b1;
			end
			tick_due = item_q.now >= tick_nd;
		end
		if (!valid_q[scan_q] || !enabled_q[scan_q]) begin
			tick_due = 1'b0;
			tick_wb = 1'b0;
		end
	end

	// Lowest-priority-value pick among due slots as a pairwise tree; the left
	// side always holds the lower indexes, so ties go to the lower index.
	logic [SW-1:0] best;
	logic found;
	logic [pts_pkg::NUM_SLOTS-1:0] due_left;
	logic [pts_pkg::NUM_SLOTS-1:0] sel_ok;
	logic [SW-1:0] sel_idx [pts_pkg::NUM_SLOTS];
	logic [pts_pkg::PRIO_W-1:0] sel_pri [pts_pkg::NUM_SLOTS];
	always_comb begin
		for (int i = 0; i < pts_pkg::NUM_SLOTS; i++) begin
			sel_ok[i] = due_q[i];
			sel_idx[i] = SW'(i);
			sel_pri[i] = prio_q[i];
		end
		for (int w = 1; w < pts_pkg::NUM_SLOTS; w = w * 2) begin
			for (int i = 0; i + w < pts_pkg::NUM_SLOTS; i = i + 2 * w) begin
				if (sel_ok[i + w] && (!sel_ok[i] || sel_pri[i + w] < sel_pri[i])) begin
					sel_ok[i] = 1'b1;
					sel_idx[i] = sel_idx[i + w];
					sel_pri[i] = sel_pri[i + w];
				end
			end
		end
		best = sel_idx[0];
		found = sel_ok[0];
		due_left = due_q;
		due_left[best] = 1'b0;
	end

	// Result words for each kind of result.
	pts_pkg::out_item_t comp_res, stats_res, due_res;
	always_comb begin
		comp_res = '0;
		comp_res.result_kind = pts_pkg::R_COMPL;
		comp_res.task_slot = item_q.slot;
		comp_res.auto_disabled = comp_dis;
		comp_res.resynced = comp_resync;
		comp_res.error_streak = comp_rec.streak;
		comp_res.run_count = comp_rec.runs;
		comp_res.fail_count = comp_rec.fails;
		comp_res.min_cost = comp_rec.cmin;
		comp_res.max_cost = comp_rec.cmax;
		comp_res.total_cost = comp_rec.csum;

		stats_res = '0;
		stats_res.result_kind = pts_pkg::R_STATS;
		stats_res.task_slot = item_q.slot;
		if (valid_q[item_q.slot]) begin
			stats_res.error_streak = rec.streak;
			stats_res.run_count = rec.runs;
			stats_res.fail_count = rec.fails;
			stats_res.min_cost = rec.cmin;
			stats_res.max_cost = rec.cmax;
			stats_res.total_cost = rec.csum;
		end else begin
			stats_res.min_cost = '1;
		end

		due_res = '0;
		due_res.result_kind = pts_pkg::R_DUE;
		due_res.task_slot = best;
		due_res.last = (due_left == '0);
	end

	// Memory port control.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = item_q.slot;
		mem_wdata = rec;
		mem_raddr = item_q.slot;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = cnt_q[SW-1:0];
				mem_wdata = cleared_rec();
			end
			ST_IDLE: mem_raddr = cmd.data.slot;
			// Start streams through all slots beginning with entry 0.
			ST_RD: mem_raddr = (item_q.kind == pts_pkg::K_START) ? '0 : item_q.slot;
			ST_EXEC: begin
				unique case (item_q.kind)
					pts_pkg::K_REGISTER, pts_pkg::K_UNREGISTER: begin
						mem_we = 1'b1;
						mem_wdata = cleared_rec();
					end
					pts_pkg::K_SET_ENABLE: begin
						mem_we = valid_q[item_q.slot] && item_q.enable;
						mem_wdata = rec;
						mem_wdata.streak = '0;
					end
					pts_pkg::K_COMPLETION: begin
						mem_we = valid_q[item_q.slot];
						mem_wdata = comp_rec;
					end
					pts_pkg::K_RESET_STATS: begin
						mem_we = valid_q[item_q.slot];
						mem_wdata = cleared_rec();
						mem_wdata.last_run = rec.last_run;
						mem_wdata.next_due = rec.next_due;
					end
					pts_pkg::K_START: begin
						mem_we = 1'b1;
						mem_waddr = cnt_q[SW-1:0];
						mem_wdata = rec;
						mem_wdata.last_run = '0;
						mem_wdata.next_due = '0;
						mem_raddr = SW'(cnt_q + 1'b1);
					end
					default: mem_we = 1'b0;
				endcase
			end
			ST_TSCAN: mem_raddr = scan_q;
			ST_TEVAL: begin
				mem_we = tick_wb;
				mem_waddr = scan_q;
				mem_wdata = rec;
				mem_wdata.next_due = tick_nd;
				mem_raddr = SW'(scan_q + 1'b1);
			end
			default: ;
		endcase
	end

	// A new result enters the output register when that register is free or
	// its transaction completes in the same cycle.
	assign out_load = (state_q == ST_OUT || (state_q == ST_TSEL && found)) &&
		(!out_valid_q || res.ready);

	assign cmd.ready = (state_q == ST_IDLE);
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	always_ff @(posedge clk) begin
		// Per-slot tables are payload; valid bits guard their use.
		if (state_q == ST_EXEC && item_q.kind == pts_pkg::K_REGISTER) begin
			prio_q[item_q.slot] <= item_q.priority_req;
			per_q[item_q.slot]  <= (item_q.period == '0) ? 31'd1 : item_q.period;
			mode_q[item_q.slot] <= item_q.mode;
			warn_q[item_q.slot] <= item_q.warn_threshold;
		end
		prod_q <= 41'(per_q[item_q.slot]) * 41'(warn_pct_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			item_q <= '0;
			warn_pct_q <= 10'd80;
			err_lim_q <= 8'd3;
			running_q <= 1'b0;
			valid_q <= '0;
			enabled_q <= '0;
			due_q <= '0;
			cnt_q <= '0;
			scan_q <= '0;
			pend_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pts_pkg::CFG_WARN_PCT:  warn_pct_q <= cfg_wdata;
					pts_pkg::CFG_ERR_LIMIT: err_lim_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == (SW+1)'(pts_pkg::NUM_SLOTS - 1)) begin
						cnt_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd.valid) begin
						item_q <= cmd.data;
						cnt_q <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (item_q.kind == pts_pkg::K_TICK) begin
						scan_q <= '0;
						due_q <= '0;
						state_q <= running_q ? ST_TSCAN : ST_IDLE;
					end else if (item_q.kind == pts_pkg::K_START && running_q) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (item_q.kind)
						pts_pkg::K_REGISTER: begin
							valid_q[item_q.slot] <= 1'b1;
							enabled_q[item_q.slot] <= 1'b1;
							state_q <= ST_IDLE;
						end
						pts_pkg::K_UNREGISTER: begin
							valid_q[item_q.slot] <= 1'b0;
							enabled_q[item_q.slot] <= 1'b0;
							state_q <= ST_IDLE;
						end
						pts_pkg::K_SET_ENABLE: begin
							if (valid_q[item_q.slot]) enabled_q[item_q.slot] <= item_q.enable;
							state_q <= ST_IDLE;
						end
						pts_pkg::K_COMPLETION: begin
							if (valid_q[item_q.slot]) begin
								if (comp_dis) enabled_q[item_q.slot] <= 1'b0;
								pend_q <= comp_res;
								state_q <= ST_WARN;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						pts_pkg::K_READ_STATS: begin
							pend_q <= stats_res;
							state_q <= ST_OUT;
						end
						pts_pkg::K_START: begin
							// One slot per cycle: clear its times.
							if (cnt_q == (SW+1)'(pts_pkg::NUM_SLOTS - 1)) begin
								running_q <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
						pts_pkg::K_STOP: begin
							running_q <= 1'b0;
							state_q <= ST_IDLE;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_WARN: begin
					// prod_q holds period * percent for this slot.
					if (warn_q[item_q.slot] != '0) begin
						pend_q.cost_warning <= item_q.cost > {1'b0, warn_q[item_q.slot]};
					end else begin
						pend_q.cost_warning <= cost_x100 > prod_q;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || res.ready) begin
						out_q <= pend_q;
						state_q <= ST_IDLE;
					end
				end
				ST_TSCAN: state_q <= ST_TEVAL;
				ST_TEVAL: begin
					due_q[scan_q] <= tick_due;
					scan_q <= scan_q + 1'b1;
					if (scan_q == SW'(pts_pkg::NUM_SLOTS - 1)) state_q <= ST_TSEL;
				end
				ST_TSEL: begin
					if (!found) begin
						state_q <= ST_IDLE;
					end else if (!out_valid_q || res.ready) begin
						out_q <= due_res;
						due_q <= due_left;
						if (due_left == '0) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	// A result transaction is never offered while a table clear is under way.
	a_no_out_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !out_valid_q) else $error("result during clear");
	// A pending result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res.ready |=> out_valid_q && $stable(out_q))
		else $error("result dropped");
	// Commands are only taken while the sequencer is idle.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> state_q == ST_IDLE) else $error("ready outside idle");
`endif
endmodule
`default_nettype wire
